>>> sv/pls_pkg.sv
// Shared constants, codes and types of the positional list store.
`default_nettype none
package pls_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int DATA_WIDTH  = 32;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int POS_W       = 5;
    localparam int CMP_W       = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    typedef logic signed [DATA_WIDTH-1:0] t_word;

    typedef enum logic [3:0] {
        OP_APPEND      = 4'd0,
        OP_INSERT      = 4'd1,
        OP_REMOVE_LAST = 4'd2,
        OP_REMOVE_AT   = 4'd3,
        OP_UPDATE      = 4'd4,
        OP_GET         = 4'd5,
        OP_FIND        = 4'd6,
        OP_ROTATE      = 4'd7,
        OP_CLEAR       = 4'd8
    } t_op;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_BADPOS   = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        SEL_HOLD  = 2'd0,
        SEL_LOAD  = 2'd1,
        SEL_LEFT  = 2'd2,
        SEL_RIGHT = 2'd3
    } t_sel;

endpackage
`default_nettype wire

>>> sv/pls_cell.sv
// One list cell: holds one entry, loads, shifts from a neighbor and compares to the key.
`default_nettype none
module pls_cell (
    input  wire logic           i_clk,
    input  wire pls_pkg::t_sel  i_sel,
    input  wire pls_pkg::t_word i_load,
    input  wire pls_pkg::t_word i_left,
    input  wire pls_pkg::t_word i_right,
    input  wire pls_pkg::t_word i_key,
    output pls_pkg::t_word      o_word,
    output logic                o_match
);

    pls_pkg::t_word r_word;
    pls_pkg::t_word n_word;

    always_comb begin
        case (i_sel)
            pls_pkg::SEL_HOLD:  n_word = r_word;
            pls_pkg::SEL_LOAD:  n_word = i_load;
            pls_pkg::SEL_LEFT:  n_word = i_left;
            pls_pkg::SEL_RIGHT: n_word = i_right;
            default:            n_word = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word  = r_word;
    assign o_match = (r_word == i_key);

endmodule
`default_nettype wire

>>> sv/positional_list_store_core.sv
// Top level of the positional list store: operation decode, cell chain and result register.
//
// Input channel i_in_valid/o_in_ready carries one word per operation: i_operation,
// i_value (data or search key) and i_position (1-based). Output channel
// o_out_valid/i_out_ready carries one result word per operation: o_status,
// o_data_out, o_found_position and o_list_length.
// The entries sit in a row of 16 cells; insert, remove at a position and rotate
// shift the affected cells by one place together, and find compares every cell at once.
// o_out_valid rises in the cycle after acceptance; throughput is one operation
// per cycle while results are taken, set by the single update of the cell row per cycle.
// The result register frees at the cycle it is taken, so a new operation is
// accepted while the previous result is delivered.
// When the receiver stalls, the result holds and o_in_ready drops until the
// result is taken; no operation is lost.
// Reset empties the list and clears the output valid flag; entries beyond the length
// are never read, so the cells need no clearing.
`default_nettype none
module positional_list_store_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [3:0]  i_operation,
    input  wire logic signed [31:0] i_value,
    input  wire logic [4:0]  i_position,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_status,
    output logic signed [31:0] o_data_out,
    output logic [4:0]       o_found_position,
    output logic [4:0]       o_list_length
);

    localparam int N    = pls_pkg::MAX_ENTRIES;
    localparam int CW   = pls_pkg::CNT_W;
    localparam int IW   = pls_pkg::IDX_W;
    localparam int PW   = pls_pkg::POS_W;
    localparam int MW   = pls_pkg::CMP_W;

    logic                   accept;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    logic                   r_out_valid;
    pls_pkg::t_status       r_status;
    pls_pkg::t_status       n_status;
    logic signed [31:0]     r_data;
    logic signed [31:0]     n_data;
    logic [PW-1:0]          r_found;
    logic [PW-1:0]          n_found;
    logic [CW-1:0]          r_len;

    pls_pkg::t_word         val_word;
    pls_pkg::t_word         rd_word;
    pls_pkg::t_word         load_word;
    logic [IW-1:0]          rd_idx;
    logic [MW-1:0]          pw_n;
    logic [MW-1:0]          pw_p;
    logic [MW-1:0]          pm1;
    logic                   is_full;
    logic                   is_empty;
    logic                   ins_bad;
    logic                   pos_bad;
    logic                   ok_append;
    logic                   ok_insert;
    logic                   ok_remove_at;
    logic                   ok_update;
    logic                   ok_rotate;
    logic [N-1:0]           hit;

    pls_pkg::t_word         cell_word  [N];
    logic [N-1:0]           cell_match;
    pls_pkg::t_sel          cell_sel   [N];

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign val_word = pls_pkg::DATA_WIDTH'(i_value);
    assign pw_n     = MW'(r_count);
    assign pw_p     = MW'(i_position);
    assign pm1      = pw_p - MW'(1);
    assign is_full  = (r_count >= CW'(N));
    assign is_empty = (r_count == '0);
    assign ins_bad  = (pw_p == '0) || (pw_p > pw_n + MW'(1));
    assign pos_bad  = (pw_p == '0) || (pw_p > pw_n);

    assign rd_idx = ((i_operation == pls_pkg::OP_REMOVE_LAST) ||
                     (i_operation == pls_pkg::OP_ROTATE)) ? IW'(pw_n - MW'(1)) : IW'(pm1);
    assign rd_word   = cell_word[rd_idx];
    assign load_word = (i_operation == pls_pkg::OP_ROTATE) ? rd_word : val_word;

    always_comb begin
        hit     = '0;
        n_found = '0;
        for (int i = N - 1; i >= 0; i--) begin
            hit[i] = cell_match[i] && (MW'(i) < pw_n);
            if (hit[i]) begin
                n_found = PW'(i + 1);
            end
        end
    end

    always_comb begin
        n_status     = pls_pkg::ST_OK;
        n_data       = '0;
        n_count      = r_count;
        ok_append    = 1'b0;
        ok_insert    = 1'b0;
        ok_remove_at = 1'b0;
        ok_update    = 1'b0;
        ok_rotate    = 1'b0;
        case (pls_pkg::t_op'(i_operation))
            pls_pkg::OP_APPEND: begin
                if (is_full) begin
                    n_status = pls_pkg::ST_FULL;
                end else begin
                    ok_append = 1'b1;
                    n_count   = r_count + CW'(1);
                end
            end
            pls_pkg::OP_INSERT: begin
                if (is_full) begin
                    n_status = pls_pkg::ST_FULL;
                end else if (ins_bad) begin
                    n_status = pls_pkg::ST_BADPOS;
                end else begin
                    ok_insert = 1'b1;
                    n_count   = r_count + CW'(1);
                end
            end
            pls_pkg::OP_REMOVE_LAST: begin
                if (is_empty) begin
                    n_status = pls_pkg::ST_EMPTY;
                end else begin
                    n_data  = 32'(rd_word);
                    n_count = r_count - CW'(1);
                end
            end
            pls_pkg::OP_REMOVE_AT: begin
                if (is_empty) begin
                    n_status = pls_pkg::ST_EMPTY;
                end else if (pos_bad) begin
                    n_status = pls_pkg::ST_BADPOS;
                end else begin
                    ok_remove_at = 1'b1;
                    n_data       = 32'(rd_word);
                    n_count      = r_count - CW'(1);
                end
            end
            pls_pkg::OP_UPDATE: begin
                if (is_empty) begin
                    n_status = pls_pkg::ST_EMPTY;
                end else if (pos_bad) begin
                    n_status = pls_pkg::ST_BADPOS;
                end else begin
                    ok_update = 1'b1;
                end
            end
            pls_pkg::OP_GET: begin
                if (is_empty) begin
                    n_status = pls_pkg::ST_EMPTY;
                end else if (pos_bad) begin
                    n_status = pls_pkg::ST_BADPOS;
                end else begin
                    n_data = 32'(rd_word);
                end
            end
            pls_pkg::OP_FIND: begin
                if (is_empty) begin
                    n_status = pls_pkg::ST_EMPTY;
                end else if (hit == '0) begin
                    n_status = pls_pkg::ST_NOTFOUND;
                end
            end
            pls_pkg::OP_ROTATE: begin
                if (is_empty) begin
                    n_status = pls_pkg::ST_EMPTY;
                end else begin
                    ok_rotate = 1'b1;
                end
            end
            pls_pkg::OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_status = pls_pkg::ST_OK;
            end
        endcase
    end

    always_comb begin
        logic [MW-1:0] ci;
        ci = '0;
        for (int i = 0; i < N; i++) begin
            ci          = MW'(i);
            cell_sel[i] = pls_pkg::SEL_HOLD;
            if (accept) begin
                if (ok_append && (ci == pw_n)) begin
                    cell_sel[i] = pls_pkg::SEL_LOAD;
                end
                if (ok_insert && (ci == pm1)) begin
                    cell_sel[i] = pls_pkg::SEL_LOAD;
                end
                if (ok_insert && (ci > pm1) && (ci <= pw_n)) begin
                    cell_sel[i] = pls_pkg::SEL_LEFT;
                end
                if (ok_remove_at && (ci >= pm1) && (ci + MW'(1) < pw_n)) begin
                    cell_sel[i] = pls_pkg::SEL_RIGHT;
                end
                if (ok_update && (ci == pm1)) begin
                    cell_sel[i] = pls_pkg::SEL_LOAD;
                end
                if (ok_rotate && (ci == '0)) begin
                    cell_sel[i] = pls_pkg::SEL_LOAD;
                end
                if (ok_rotate && (ci != '0) && (ci < pw_n)) begin
                    cell_sel[i] = pls_pkg::SEL_LEFT;
                end
            end
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_cell
        pls_pkg::t_word left_word;
        pls_pkg::t_word right_word;
        if (g == 0) begin : g_first
            assign left_word = '0;
        end else begin : g_inner_left
            assign left_word = cell_word[g-1];
        end
        if (g == N - 1) begin : g_last
            assign right_word = '0;
        end else begin : g_inner_right
            assign right_word = cell_word[g+1];
        end
        pls_cell u_cell (
            .i_clk   (i_clk),
            .i_sel   (cell_sel[g]),
            .i_load  (load_word),
            .i_left  (left_word),
            .i_right (right_word),
            .i_key   (val_word),
            .o_word  (cell_word[g]),
            .o_match (cell_match[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_data   <= n_data;
            r_found  <= ((i_operation == pls_pkg::OP_FIND) && (n_status == pls_pkg::ST_OK)) ?
                        n_found : '0;
            r_len    <= n_count;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_data_out       = r_data;
    assign o_found_position = r_found;
    assign o_list_length    = 5'(r_len);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(N))
        else $error("list length above capacity");

    a_len_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (o_list_length == 5'(r_count)) && o_out_valid)
        else $error("reported length differs from stored length");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_operation == pls_pkg::OP_APPEND) && (r_count < CW'(N)))
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("append did not grow the list");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_operation == pls_pkg::OP_CLEAR))
        |=> (r_count == '0) && (o_status == pls_pkg::ST_OK))
        else $error("clear left entries");

endmodule
`default_nettype wire
